// ===== hw/rtl/vector_axis_angle_rotation_unit_macros.svh =====
// Assertion macros for the vector axis-angle rotation unit
`ifndef VECTOR_AXIS_ANGLE_ROTATION_UNIT_MACROS_SVH
`define VECTOR_AXIS_ANGLE_ROTATION_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VAR_ASSERT_IMP(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define VAR_ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define VAR_ASSERT_IMP(label, clk, rst, a, c, msg)
`define VAR_ASSERT_NEXT(label, clk, rst, a, c, msg)
`endif
`endif

// ===== hw/rtl/varot_pkg.sv =====
// Shared types, constants and angle table for the rotation unit
package varot_pkg;
   localparam int COORD_WIDTH_DEF  = 32;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_ENTRIES     = 24;

   localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [35:0] INV_GAIN_Q30 = 36'sd652032874;

   typedef struct packed {
      logic signed [COORD_WIDTH_DEF-1:0] r_x;
      logic signed [COORD_WIDTH_DEF-1:0] r_y;
      logic signed [COORD_WIDTH_DEF-1:0] r_z;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
      logic signed [15:0] angle;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH_DEF-1:0] out_x;
      logic signed [COORD_WIDTH_DEF-1:0] out_y;
      logic signed [COORD_WIDTH_DEF-1:0] out_z;
      logic               saturated;
   } rsp_type;

   function automatic logic signed [35:0] atan_q30(input int idx);
      logic signed [35:0] t [0:ATAN_ENTRIES-1];
      t = '{36'sd843314857, 36'sd497837830, 36'sd263043837, 36'sd133525159,
            36'sd67021687, 36'sd33543516, 36'sd16775851, 36'sd8388437,
            36'sd4194283, 36'sd2097149, 36'sd1048576, 36'sd524288,
            36'sd262144, 36'sd131072, 36'sd65536, 36'sd32768,
            36'sd16384, 36'sd8192, 36'sd4096, 36'sd2048,
            36'sd1024, 36'sd512, 36'sd256, 36'sd128};
      return t[idx];
   endfunction
endpackage

// ===== hw/rtl/varot_cordic.sv =====
// Pipelined CORDIC giving cos and sin of a Q3.12 angle as Q1.14
module varot_cordic #(
   parameter int STEPS = varot_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid_in,
   input  logic signed [15:0] angle_in,
   output logic               valid_out,
   output logic signed [15:0] cos_out,
   output logic signed [15:0] sin_out
);
   import varot_pkg::*;

   localparam int N = (STEPS < ATAN_ENTRIES) ? STEPS : ATAN_ENTRIES;

   logic               v_ff   [0:N];
   logic signed [35:0] x_ff   [0:N];
   logic signed [35:0] y_ff   [0:N];
   logic signed [35:0] z_ff   [0:N];
   logic               flip_ff[0:N];
   logic signed [35:0] z0_in, zw;
   logic               flip_in;
   logic signed [35:0] xo, yo, xr, yr;
   logic               v_out_ff;
   logic signed [15:0] c_ff, s_ff;

   // wrap the angle into [-pi/2, pi/2]
   always_comb begin
      zw = 36'(angle_in) <<< 18;
      if (zw > PI_Q30) zw = zw - TWO_PI_Q30;
      else if (zw < -PI_Q30) zw = zw + TWO_PI_Q30;
      flip_in = 1'b0;
      z0_in   = zw;
      if (zw > HALF_PI_Q30) begin
         z0_in = zw - PI_Q30;
         flip_in = 1'b1;
      end else if (zw < -HALF_PI_Q30) begin
         z0_in = zw + PI_Q30;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else v_ff[0] <= valid_in;
      x_ff[0] <= INV_GAIN_Q30;
      y_ff[0] <= '0;
      z_ff[0] <= z0_in;
      flip_ff[0] <= flip_in;
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < N; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) v_ff[i+1] <= 1'b0;
         else v_ff[i+1] <= v_ff[i];
         flip_ff[i+1] <= flip_ff[i];
         if (z_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - atan_q30(i);
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + atan_q30(i);
         end
      end
   end

   // negate, round to Q1.14, clamp to unit
   always_comb begin
      xo = flip_ff[N] ? -x_ff[N] : x_ff[N];
      yo = flip_ff[N] ? -y_ff[N] : y_ff[N];
      xr = (xo + 36'sd32768) >>> 16;
      yr = (yo + 36'sd32768) >>> 16;
      if (xr > 36'sd16384) xr = 36'sd16384;
      else if (xr < -36'sd16384) xr = -36'sd16384;
      if (yr > 36'sd16384) yr = 36'sd16384;
      else if (yr < -36'sd16384) yr = -36'sd16384;
   end

   always_ff @(posedge clock) begin
      if (reset) v_out_ff <= 1'b0;
      else v_out_ff <= v_ff[N];
      c_ff <= xr[15:0];
      s_ff <= yr[15:0];
   end

   assign valid_out = v_out_ff;
   assign cos_out   = c_ff;
   assign sin_out   = s_ff;
endmodule

// ===== hw/rtl/varot_delay.sv =====
// Delay line carrying the input item alongside the CORDIC
module varot_delay #(
   parameter int DEPTH = 1
) (
   input  logic              clock,
   input  varot_pkg::req_type d_in,
   output varot_pkg::req_type d_out
);
   import varot_pkg::*;

   req_type tap_ff [0:DEPTH-1];

   // advance every tap each cycle
   always_ff @(posedge clock) begin
      tap_ff[0] <= d_in;
      for (int i = 1; i < DEPTH; i++) tap_ff[i] <= tap_ff[i-1];
   end

   assign d_out = tap_ff[DEPTH-1];
endmodule

// ===== hw/rtl/varot_combine.sv =====
// Pipelined dot, cross and Rodrigues combine with saturation
module varot_combine (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid_in,
   input  varot_pkg::req_type item_in,
   input  logic signed [15:0] cos_in,
   input  logic signed [15:0] sin_in,
   output logic               valid_out,
   output varot_pkg::rsp_type rsp_out
);
   import varot_pkg::*;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int PW = CW + 18;
   localparam logic signed [PW-1:0] HI = PW'((64'sd1 <<< (CW-1)) - 1);
   localparam logic signed [PW-1:0] LO = -HI - 1;
   localparam logic signed [PW-1:0] HALF = PW'(8192);

   function automatic logic signed [PW-1:0] rnd14(input logic signed [PW-1:0] v);
      return (v + HALF) >>> 14;
   endfunction
   function automatic logic signed [CW-1:0] satw(input logic signed [PW-1:0] v);
      if (v > HI) return CW'(HI);
      if (v < LO) return CW'(LO);
      return CW'(v);
   endfunction
   function automatic logic clipw(input logic signed [PW-1:0] v);
      return (v > HI) || (v < LO);
   endfunction

   logic signed [CW-1:0] r_in [0:2];
   logic signed [15:0]   n_in [0:2];

   // stage 1: twelve products
   logic signed [PW-1:0] pd_ff [0:2];
   logic signed [PW-1:0] px_ff [0:5];
   logic signed [PW-1:0] pc_ff [0:2];
   logic signed [CW-1:0] r1_ff [0:2];
   logic signed [15:0]   n1_ff [0:2], n2_ff [0:2], n3_ff [0:2];
   logic signed [15:0]   c1_ff, s1_ff, c2_ff, s2_ff;
   logic                 v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   // stage 2: dot and cross saturated
   logic signed [CW-1:0] dot2_ff;
   logic signed [CW-1:0] cr2_ff [0:2];
   logic signed [PW-1:0] rc2_ff [0:2];
   logic                 clip2_ff;
   // stage 3: k product and cross*sin
   logic signed [PW-1:0] kp3_ff;
   logic signed [PW-1:0] cs3_ff [0:2];
   logic signed [PW-1:0] rc3_ff [0:2];
   logic                 clip3_ff;
   // stage 4: k and n*k
   logic signed [PW-1:0] nk4_ff [0:2];
   logic signed [PW-1:0] cs4_ff [0:2];
   logic signed [PW-1:0] rc4_ff [0:2];
   logic                 clip4_ff;
   logic signed [CW-1:0] k_w;
   // output
   rsp_type              rsp_ff;
   logic signed [PW-1:0] sum_w [0:2];
   logic signed [PW-1:0] dsum_w;
   logic signed [PW-1:0] cx_w [0:2];
   logic signed [PW-1:0] kr_w;

   assign r_in[0] = CW'(item_in.r_x);
   assign r_in[1] = CW'(item_in.r_y);
   assign r_in[2] = CW'(item_in.r_z);
   assign n_in[0] = item_in.axis_x;
   assign n_in[1] = item_in.axis_y;
   assign n_in[2] = item_in.axis_z;

   // products of axis and vector, and of vector and cos
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         pd_ff[i] <= PW'(r_in[i]) * PW'(n_in[i]);
         pc_ff[i] <= PW'(r_in[i]) * PW'(cos_in);
         r1_ff[i] <= r_in[i];
         n1_ff[i] <= n_in[i];
      end
      px_ff[0] <= PW'(r_in[1]) * PW'(n_in[2]);
      px_ff[1] <= PW'(r_in[2]) * PW'(n_in[1]);
      px_ff[2] <= PW'(r_in[2]) * PW'(n_in[0]);
      px_ff[3] <= PW'(r_in[0]) * PW'(n_in[2]);
      px_ff[4] <= PW'(r_in[0]) * PW'(n_in[1]);
      px_ff[5] <= PW'(r_in[1]) * PW'(n_in[0]);
      c1_ff <= cos_in;
      s1_ff <= sin_in;
   end

   always_comb begin
      dsum_w = rnd14(pd_ff[0]) + rnd14(pd_ff[1]) + rnd14(pd_ff[2]);
      for (int i = 0; i < 3; i++)
         cx_w[i] = rnd14(px_ff[2*i]) - rnd14(px_ff[2*i+1]);
   end

   // saturate dot and cross
   always_ff @(posedge clock) begin
      dot2_ff <= satw(dsum_w);
      for (int i = 0; i < 3; i++) begin
         cr2_ff[i] <= satw(cx_w[i]);
         rc2_ff[i] <= rnd14(pc_ff[i]);
         n2_ff[i]  <= n1_ff[i];
      end
      clip2_ff <= clipw(dsum_w) | clipw(cx_w[0]) | clipw(cx_w[1]) | clipw(cx_w[2]);
      c2_ff <= c1_ff;
      s2_ff <= s1_ff;
   end

   // multiply dot by (1 - cos), cross by sin
   always_ff @(posedge clock) begin
      kp3_ff <= PW'(dot2_ff) * (PW'(17'sd16384) - PW'(c2_ff));
      for (int i = 0; i < 3; i++) begin
         cs3_ff[i] <= PW'(cr2_ff[i]) * PW'(s2_ff);
         rc3_ff[i] <= rc2_ff[i];
         n3_ff[i]  <= n2_ff[i];
      end
      clip3_ff <= clip2_ff;
   end

   assign kr_w = rnd14(kp3_ff);
   assign k_w  = satw(kr_w);

   // multiply axis by k
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         nk4_ff[i] <= PW'(n3_ff[i]) * PW'(k_w);
         cs4_ff[i] <= rnd14(cs3_ff[i]);
         rc4_ff[i] <= rc3_ff[i];
      end
      clip4_ff <= clip3_ff | clipw(kr_w);
   end

   always_comb begin
      for (int i = 0; i < 3; i++)
         sum_w[i] = rc4_ff[i] + rnd14(nk4_ff[i]) + cs4_ff[i];
   end

   // sum, saturate and register the result
   always_ff @(posedge clock) begin
      rsp_ff.out_x <= satw(sum_w[0]);
      rsp_ff.out_y <= satw(sum_w[1]);
      rsp_ff.out_z <= satw(sum_w[2]);
      rsp_ff.saturated <= clip4_ff | clipw(sum_w[0]) | clipw(sum_w[1]) | clipw(sum_w[2]);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0; v5_ff <= 1'b0;
      end else begin
         v1_ff <= valid_in; v2_ff <= v1_ff; v3_ff <= v2_ff;
         v4_ff <= v3_ff; v5_ff <= v4_ff;
      end
   end

   assign valid_out = v5_ff;
   assign rsp_out   = rsp_ff;
endmodule

// ===== hw/rtl/vector_axis_angle_rotation_unit.sv =====
// Top level of the axis-angle vector rotation unit
//
// channel  ports                     handshake
// input    req_item                  start & !busy
// result   rsp_item                  rsp_strobe, one cycle, no back-pressure
//
// One item may enter every cycle; busy is always low.
// An item passes CORDIC_STEPS + 7 registers (steps capped at 24): the CORDIC input
// register, one per step and its output register, then the five combine stages.
// Reset clears only the valid bits; the data path needs none.
`include "vector_axis_angle_rotation_unit_macros.svh"
module vector_axis_angle_rotation_unit #(
   parameter int CORDIC_STEPS = varot_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  varot_pkg::req_type req_item,
   output logic               rsp_strobe,
   output varot_pkg::rsp_type rsp_item
);
   import varot_pkg::*;

   localparam int NSTEP = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

   logic               acc;
   logic               trig_valid;
   logic signed [15:0] cos_w, sin_w;
   req_type            item_d;

   assign busy = 1'b0;
   assign acc  = start & ~busy;

   varot_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock, .reset, .valid_in(acc), .angle_in(req_item.angle),
      .valid_out(trig_valid), .cos_out(cos_w), .sin_out(sin_w)
   );

   // hold the item for as long as the CORDIC runs
   varot_delay #(.DEPTH(NSTEP + 2)) u_delay (
      .clock, .d_in(req_item), .d_out(item_d)
   );

   varot_combine u_combine (
      .clock, .reset, .valid_in(trig_valid), .item_in(item_d),
      .cos_in(cos_w), .sin_in(sin_w),
      .valid_out(rsp_strobe), .rsp_out(rsp_item)
   );

   `VAR_ASSERT_IMP(a_busy_low, clock, reset, 1'b1, !busy, "busy raised")
   `VAR_ASSERT_NEXT(a_no_strobe_after_reset, clock, 1'b0, reset, !rsp_strobe, "strobe")
   `VAR_ASSERT_IMP(a_cos_unit, clock, reset, trig_valid, (cos_w * cos_w <= 32'sd268435456), "cos")
endmodule
